// ----- src/nrp_pkg.sv -----
// shared types, constants and helper functions for the nmea rmc position parser
// no dependencies
package nrp_pkg;

  localparam int LINE_LIMIT_DEF  = 127;
  localparam int FRAC_DIGITS_DEF = 5;
  localparam int QUEUE_DEPTH     = 4;

  localparam int WHOLE_W    = 17;
  localparam int FRAC_W     = 24;
  localparam int SPD_FRAC_W = 7;
  localparam int MAG_W      = 34;
  localparam int COORD_W    = 36;
  localparam int SPEED_W    = 24;

  localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd99999;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_MAX    = 4'd15;

  // one finished line, raw parts already zeroed when there is no active fix
  typedef struct packed {
    logic                  rmc_seen;
    logic                  active;
    logic                  overflow;
    logic [WHOLE_W-1:0]    lat_whole;
    logic [FRAC_W-1:0]     lat_frac;
    logic                  lat_neg;
    logic [WHOLE_W-1:0]    lon_whole;
    logic [FRAC_W-1:0]     lon_frac;
    logic                  lon_neg;
    logic [WHOLE_W-1:0]    spd_whole;
    logic [SPD_FRAC_W-1:0] spd_frac;
  } nrp_rec_t;

  // flags and speed that ride along the conversion pipeline
  typedef struct packed {
    logic               rmc_seen;
    logic               active;
    logic               overflow;
    logic               lat_neg;
    logic               lon_neg;
    logic [SPEED_W-1:0] speed;
  } nrp_side_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] n);
    logic [FRAC_W-1:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// ----- src/nrp_front.sv -----
// front end: accepts bytes, tracks the line and rmc fields, emits one record per line
// depends on nrp_pkg
module nrp_front #(
  parameter int LINE_LIMIT      = nrp_pkg::LINE_LIMIT_DEF,
  parameter int FRACTION_DIGITS = nrp_pkg::FRAC_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_rx_byte,
  output logic             in_stall,
  input  logic             q_full,
  output logic             push,
  output nrp_pkg::nrp_rec_t push_rec
);
  import nrp_pkg::*;

  localparam int LEN_W = $clog2(LINE_LIMIT + 1);

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [15:0]           recent_r, recent_nxt;
  logic                  matched_r, matched_nxt;
  logic [3:0]            fnum_r, fnum_nxt;
  logic [6:0]            fcnt_r, fcnt_nxt;
  logic                  active_r, active_nxt;
  logic                  ndone_r, ndone_nxt;
  logic                  point_r, point_nxt;
  logic [2:0]            fdig_r, fdig_nxt;
  logic [WHOLE_W-1:0]    lat_whole_r, lat_whole_nxt;
  logic [FRAC_W-1:0]     lat_frac_r, lat_frac_nxt;
  logic                  south_r, south_nxt;
  logic [WHOLE_W-1:0]    lon_whole_r, lon_whole_nxt;
  logic [FRAC_W-1:0]     lon_frac_r, lon_frac_nxt;
  logic                  west_r, west_nxt;
  logic [WHOLE_W-1:0]    sw_r, sw_nxt;
  logic [SPD_FRAC_W-1:0] sf_r, sf_nxt;

  logic                  accept, line_end, is_digit, first, num_fld;
  logic [3:0]            dval;
  logic [2:0]            flen;
  logic [WHOLE_W-1:0]    cur_whole, new_whole;
  logic [FRAC_W-1:0]     cur_frac, new_frac;
  logic [20:0]           w_mul;
  logic                  upd_whole, upd_frac;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign line_end = (in_rx_byte == CH_LF) || (32'(len_r) >= LINE_LIMIT);
  assign is_digit = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign dval     = in_rx_byte[3:0];
  assign first    = (fcnt_r == 7'd0);
  assign num_fld  = (fnum_r == FLD_LAT) || (fnum_r == FLD_LON) || (fnum_r == FLD_SPEED);

  // shared number accumulator for the field in progress
  always_comb begin
    case (fnum_r)
      FLD_LAT: begin
        cur_whole = lat_whole_r;
        cur_frac  = lat_frac_r;
      end
      FLD_LON: begin
        cur_whole = lon_whole_r;
        cur_frac  = lon_frac_r;
      end
      default: begin
        cur_whole = sw_r;
        cur_frac  = FRAC_W'(sf_r);
      end
    endcase
    flen      = (fnum_r == FLD_SPEED) ? 3'd2 : 3'(FRACTION_DIGITS);
    w_mul     = 21'(cur_whole) * 21'd10 + 21'(dval);
    new_whole = (w_mul > 21'(WHOLE_MAX)) ? WHOLE_MAX : w_mul[WHOLE_W-1:0];
    new_frac  = cur_frac + FRAC_W'(dval) * pow10(3'(flen - 3'd1 - fdig_r));
  end

  always_comb begin
    len_nxt       = len_r;
    recent_nxt    = recent_r;
    matched_nxt   = matched_r;
    fnum_nxt      = fnum_r;
    fcnt_nxt      = fcnt_r;
    active_nxt    = active_r;
    ndone_nxt     = ndone_r;
    point_nxt     = point_r;
    fdig_nxt      = fdig_r;
    lat_whole_nxt = lat_whole_r;
    lat_frac_nxt  = lat_frac_r;
    south_nxt     = south_r;
    lon_whole_nxt = lon_whole_r;
    lon_frac_nxt  = lon_frac_r;
    west_nxt      = west_r;
    sw_nxt        = sw_r;
    sf_nxt        = sf_r;
    upd_whole     = 1'b0;
    upd_frac      = 1'b0;
    push          = 1'b0;

    if (accept) begin
      if (line_end) begin
        push          = 1'b1;
        len_nxt       = '0;
        recent_nxt    = '0;
        matched_nxt   = 1'b0;
        fnum_nxt      = '0;
        fcnt_nxt      = '0;
        active_nxt    = 1'b0;
        ndone_nxt     = 1'b0;
        point_nxt     = 1'b0;
        fdig_nxt      = '0;
        lat_whole_nxt = '0;
        lat_frac_nxt  = '0;
        south_nxt     = 1'b0;
        lon_whole_nxt = '0;
        lon_frac_nxt  = '0;
        west_nxt      = 1'b0;
        sw_nxt        = '0;
        sf_nxt        = '0;
      end else begin
        len_nxt    = len_r + LEN_W'(1);
        recent_nxt = {recent_r[7:0], in_rx_byte};
        if (matched_r) begin
          if (in_rx_byte == CH_COMMA) begin
            if (fnum_r != FLD_MAX) fnum_nxt = fnum_r + 4'd1;
            fcnt_nxt  = '0;
            ndone_nxt = 1'b0;
            point_nxt = 1'b0;
            fdig_nxt  = '0;
          end else begin
            case (fnum_r)
              FLD_STATUS: if (first && in_rx_byte == CH_A) active_nxt = 1'b1;
              FLD_NS:     if (first && in_rx_byte == CH_S) south_nxt = 1'b1;
              FLD_EW:     if (first && in_rx_byte == CH_W) west_nxt = 1'b1;
              default:    ;
            endcase
            if (num_fld && !ndone_r) begin
              if (is_digit) begin
                if (!point_r) begin
                  upd_whole = 1'b1;
                end else if (fdig_r < flen) begin
                  upd_frac = 1'b1;
                  fdig_nxt = fdig_r + 3'd1;
                end
              end else if (in_rx_byte == CH_DOT && !point_r) begin
                point_nxt = 1'b1;
              end else begin
                ndone_nxt = 1'b1;
              end
            end
            if (fcnt_r != 7'd127) fcnt_nxt = fcnt_r + 7'd1;
          end
        end else if (recent_r == {CH_R, CH_M} && in_rx_byte == CH_C) begin
          matched_nxt = 1'b1;
          fnum_nxt    = '0;
          fcnt_nxt    = '0;
        end

        case (fnum_r)
          FLD_LAT: begin
            if (upd_whole) lat_whole_nxt = new_whole;
            if (upd_frac)  lat_frac_nxt  = new_frac;
          end
          FLD_LON: begin
            if (upd_whole) lon_whole_nxt = new_whole;
            if (upd_frac)  lon_frac_nxt  = new_frac;
          end
          FLD_SPEED: begin
            if (upd_whole) sw_nxt = new_whole;
            if (upd_frac)  sf_nxt = new_frac[SPD_FRAC_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // record of the line that ends with this byte
  always_comb begin
    logic ok;
    ok                 = matched_r && active_r;
    push_rec           = '0;
    push_rec.rmc_seen  = matched_r;
    push_rec.active    = ok;
    push_rec.overflow  = (in_rx_byte != CH_LF);
    if (ok) begin
      push_rec.lat_whole = lat_whole_r;
      push_rec.lat_frac  = lat_frac_r;
      push_rec.lat_neg   = south_r;
      push_rec.lon_whole = lon_whole_r;
      push_rec.lon_frac  = lon_frac_r;
      push_rec.lon_neg   = west_r;
      push_rec.spd_whole = sw_r;
      push_rec.spd_frac  = sf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      recent_r    <= '0;
      matched_r   <= 1'b0;
      fnum_r      <= '0;
      fcnt_r      <= '0;
      active_r    <= 1'b0;
      ndone_r     <= 1'b0;
      point_r     <= 1'b0;
      fdig_r      <= '0;
      lat_whole_r <= '0;
      lat_frac_r  <= '0;
      south_r     <= 1'b0;
      lon_whole_r <= '0;
      lon_frac_r  <= '0;
      west_r      <= 1'b0;
      sw_r        <= '0;
      sf_r        <= '0;
    end else begin
      len_r       <= len_nxt;
      recent_r    <= recent_nxt;
      matched_r   <= matched_nxt;
      fnum_r      <= fnum_nxt;
      fcnt_r      <= fcnt_nxt;
      active_r    <= active_nxt;
      ndone_r     <= ndone_nxt;
      point_r     <= point_nxt;
      fdig_r      <= fdig_nxt;
      lat_whole_r <= lat_whole_nxt;
      lat_frac_r  <= lat_frac_nxt;
      south_r     <= south_nxt;
      lon_whole_r <= lon_whole_nxt;
      lon_frac_r  <= lon_frac_nxt;
      west_r      <= west_nxt;
      sw_r        <= sw_nxt;
      sf_r        <= sf_nxt;
    end
  end

endmodule

// ----- src/nrp_queue.sv -----
// small record queue between the front end and the conversion pipeline
// depends on nrp_pkg
module nrp_queue #(
  parameter int DEPTH = nrp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nrp_pkg::nrp_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output nrp_pkg::nrp_rec_t pop_rec,
  output logic              not_empty
);
  import nrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nrp_rec_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (32'(cnt_r) == DEPTH);
  assign not_empty = (cnt_r != '0);
  assign pop_rec   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (32'(wr_r) == DEPTH - 1) ? '0 : wr_r + PTR_W'(1);
    if (pop)  rd_nxt = (32'(rd_r) == DEPTH - 1) ? '0 : rd_r + PTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/nrp_coord.sv -----
// eight-stage ddmm.mmmmm to 1e-7 degree magnitude conversion, reciprocal divides
// depends on nrp_pkg
module nrp_coord #(
  parameter int FRACTION_DIGITS = nrp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [nrp_pkg::WHOLE_W-1:0] whole,
  input  logic [nrp_pkg::FRAC_W-1:0]  frac,
  output logic [nrp_pkg::MAG_W-1:0]   mag
);
  import nrp_pkg::*;

  localparam logic [FRAC_W-1:0] SCALE   = pow10(3'(FRACTION_DIGITS));
  localparam logic [FRAC_W-1:0] UPSCALE = pow10(3'(7 - FRACTION_DIGITS));
  // floor(2^20 / 100) and floor(2^32 / 15): quotients low by at most one
  localparam logic [13:0] RECIP100 = 14'd10485;
  localparam logic [28:0] RECIP15  = 29'd286331153;

  logic [WHOLE_W-1:0] whole1_r, q0_1_r, q0_2_r;
  logic [FRAC_W-1:0]  frac1_r, frac2_r, frac3_r;
  logic [7:0]         r0_2_r;
  logic [9:0]         deg3_r;
  logic [6:0]         rem3_r;
  logic [29:0]        min4_r, x5_r;
  logic [MAG_W-1:0]   dege7_4_r, dege7_5_r, dege7_6_r, dege7_7_r, mag_r;
  logic [27:0]        y6_r;
  logic [24:0]        q1_6_r, q1_7_r;
  logic [4:0]         rem7_r;

  logic [WHOLE_W-1:0] r0_full;
  logic [27:0]        r1_full;

  assign r0_full = whole1_r - WHOLE_W'(q0_1_r * 17'd100);
  assign r1_full = y6_r - 28'(q1_6_r * 25'd15);
  assign mag     = mag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // degrees estimate: whole / 100
      q0_1_r    <= WHOLE_W'((31'(whole) * 31'(RECIP100)) >> 20);
      whole1_r  <= whole;
      frac1_r   <= frac;
      // remainder of the estimate
      q0_2_r    <= q0_1_r;
      r0_2_r    <= r0_full[7:0];
      frac2_r   <= frac1_r;
      // correct by one
      if (r0_2_r >= 8'd100) begin
        deg3_r <= 10'(q0_2_r + 17'd1);
        rem3_r <= 7'(r0_2_r - 8'd100);
      end else begin
        deg3_r <= 10'(q0_2_r);
        rem3_r <= r0_2_r[6:0];
      end
      frac3_r   <= frac2_r;
      // minutes scaled to the fraction digits, whole degrees in 1e-7
      min4_r    <= 30'(30'(rem3_r) * 30'(SCALE)) + 30'(frac3_r);
      dege7_4_r <= MAG_W'(deg3_r) * MAG_W'(24'd10000000);
      // minutes in 1e-7 minute units
      x5_r      <= 30'(min4_r * 30'(UPSCALE));
      dege7_5_r <= dege7_4_r;
      // divide by 60 as (x / 4) / 15
      y6_r      <= x5_r[29:2];
      q1_6_r    <= 25'((57'(x5_r[29:2]) * 57'(RECIP15)) >> 32);
      dege7_6_r <= dege7_5_r;
      q1_7_r    <= q1_6_r;
      rem7_r    <= r1_full[4:0];
      dege7_7_r <= dege7_6_r;
      mag_r     <= dege7_7_r + MAG_W'(q1_7_r) + MAG_W'(rem7_r >= 5'd15);
    end
  end

endmodule

// ----- src/nrp_back.sv -----
// back end: pops records, converts both coordinates and speed, holds the result register
// depends on nrp_pkg, nrp_coord
module nrp_back #(
  parameter int FRACTION_DIGITS = nrp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rec_valid,
  input  nrp_pkg::nrp_rec_t           rec,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_fix_valid,
  output logic                        out_rmc_seen,
  output logic signed [nrp_pkg::COORD_W-1:0] out_latitude_e7,
  output logic signed [nrp_pkg::COORD_W-1:0] out_longitude_e7,
  output logic [nrp_pkg::SPEED_W-1:0] out_speed_centiknots,
  output logic                        out_line_overflow
);
  import nrp_pkg::*;

  localparam int STAGES = 8;

  logic             adv;
  logic             v_r [STAGES];
  nrp_side_t        side_r [STAGES];
  nrp_side_t        side_in;
  logic [MAG_W-1:0] lat_mag, lon_mag;
  logic             out_valid_r;

  // whole pipeline moves whenever the result register is free or being taken
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && rec_valid;

  always_comb begin
    side_in          = '0;
    side_in.rmc_seen = rec.rmc_seen;
    side_in.active   = rec.active;
    side_in.overflow = rec.overflow;
    side_in.lat_neg  = rec.lat_neg;
    side_in.lon_neg  = rec.lon_neg;
    side_in.speed    = SPEED_W'(SPEED_W'(rec.spd_whole) * SPEED_W'(100)) +
                       SPEED_W'(rec.spd_frac);
  end

  nrp_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lat (
    .clk(clk), .adv(adv), .whole(rec.lat_whole), .frac(rec.lat_frac), .mag(lat_mag)
  );

  nrp_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lon (
    .clk(clk), .adv(adv), .whole(rec.lon_whole), .frac(rec.lon_frac), .mag(lon_mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= rec_valid;
      for (int i = 1; i < STAGES; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fix_valid        <= side_r[STAGES-1].active && (lat_mag != '0) && (lon_mag != '0);
      out_rmc_seen         <= side_r[STAGES-1].rmc_seen;
      out_line_overflow    <= side_r[STAGES-1].overflow;
      out_speed_centiknots <= side_r[STAGES-1].speed;
      out_latitude_e7      <= side_r[STAGES-1].lat_neg ? -$signed(COORD_W'(lat_mag))
                                                       : $signed(COORD_W'(lat_mag));
      out_longitude_e7     <= side_r[STAGES-1].lon_neg ? -$signed(COORD_W'(lon_mag))
                                                       : $signed(COORD_W'(lon_mag));
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/nmea_rmc_position_parser_top.sv -----
// top level of the nmea rmc position parser
// depends on nrp_pkg, nrp_front, nrp_queue, nrp_back
//
// usage
//   input channel: one received character per transaction on in_rx_byte,
//   taken when in_valid is high and in_stall is low
//   every newline, and every byte that arrives while LINE_LIMIT bytes are
//   already held, ends a line; that byte is not part of the line
//   output channel: one transaction per line end with fix flag, rmc flag,
//   signed latitude and longitude in 1e-7 degree, speed in 0.01 knot and
//   the length-overflow flag
//   throughput: one byte per cycle while in_stall is low; the front parser
//   updates all of its field state as each byte is taken
//   result path: the record of the line-ending byte is written to the queue,
//   then passes eight conversion stages and the result register; the
//   stage count is set by the reciprocal divides by 100 and by 60 in each
//   coordinate unit
//   a queue of QUEUE_DEPTH records decouples the parser from the conversion
//   pipeline; when the receiver stalls, the pipeline and result register
//   hold, the queue fills, and only then does in_stall rise
//   reset clears the line state, the queue and all pipeline valid bits
module nmea_rmc_position_parser_top #(
  parameter int LINE_LIMIT      = nrp_pkg::LINE_LIMIT_DEF,
  parameter int FRACTION_DIGITS = nrp_pkg::FRAC_DIGITS_DEF,
  parameter int QUEUE_DEPTH     = nrp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_fix_valid,
  output logic                        out_rmc_seen,
  output logic signed [nrp_pkg::COORD_W-1:0] out_latitude_e7,
  output logic signed [nrp_pkg::COORD_W-1:0] out_longitude_e7,
  output logic [nrp_pkg::SPEED_W-1:0] out_speed_centiknots,
  output logic                        out_line_overflow
);
  import nrp_pkg::*;

  // front to queue
  logic     push, q_full;
  nrp_rec_t push_rec;
  // queue to back
  logic     pop, q_not_empty;
  nrp_rec_t pop_rec;

  // byte parser: line length, rmc match, field counting, number accumulation
  nrp_front #(
    .LINE_LIMIT(LINE_LIMIT),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_rx_byte(in_rx_byte), .in_stall(in_stall),
    .q_full(q_full), .push(push), .push_rec(push_rec)
  );

  // line records waiting for conversion
  nrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_rec(push_rec), .full(q_full),
    .pop(pop), .pop_rec(pop_rec), .not_empty(q_not_empty)
  );

  // fixed-point conversion and result register
  nrp_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .rec_valid(q_not_empty), .rec(pop_rec), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_fix_valid(out_fix_valid), .out_rmc_seen(out_rmc_seen),
    .out_latitude_e7(out_latitude_e7), .out_longitude_e7(out_longitude_e7),
    .out_speed_centiknots(out_speed_centiknots),
    .out_line_overflow(out_line_overflow)
  );

endmodule

// ----- src/nrp_checker.sv -----
// port-level checks for the nmea rmc position parser, bound to the top level
// depends on nmea_rmc_position_parser_top
module nrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_fix_valid,
  input logic        out_rmc_seen,
  input logic [35:0] out_latitude_e7,
  input logic [35:0] out_longitude_e7,
  input logic [23:0] out_speed_centiknots
);

  // a stalled transaction stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a fix needs an rmc sentence
  a_fix_rmc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_valid |-> out_rmc_seen)
    else $error("fix without rmc");

  // without rmc all numbers are zero
  a_no_rmc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rmc_seen |->
      out_latitude_e7 == 36'd0 && out_longitude_e7 == 36'd0 &&
      out_speed_centiknots == 24'd0)
    else $error("values without rmc");

  // a fix has both coordinates nonzero
  a_fix_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_valid |->
      out_latitude_e7 != 36'd0 && out_longitude_e7 != 36'd0)
    else $error("fix with zero coordinate");

endmodule

bind nmea_rmc_position_parser_top nrp_checker u_nrp_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_fix_valid(out_fix_valid), .out_rmc_seen(out_rmc_seen),
  .out_latitude_e7(out_latitude_e7), .out_longitude_e7(out_longitude_e7),
  .out_speed_centiknots(out_speed_centiknots)
);

// ----- test/nmea_rmc_position_parser_top_tb.sv -----
// testbench for the nmea rmc position parser top level
// depends on nrp_pkg and nmea_rmc_position_parser_top; self-checking against a built-in line model
`timescale 1ns / 100ps

module nmea_rmc_position_parser_top_tb;
  import nrp_pkg::*;

  localparam int LINE_MAX   = LINE_LIMIT_DEF;
  localparam int FRAC_N     = FRAC_DIGITS_DEF;
  localparam int IDLE_PCT   = 31;
  localparam int STALL_HOLD = 200;
  localparam int WDOG_LIMIT = 4000;

  // one expected line result
  typedef struct {
    logic                      fix;
    logic                      rmc;
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    logic [SPEED_W-1:0]        spd;
    logic                      ovf;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_fix_valid, out_rmc_seen, out_line_overflow;
  logic signed [COORD_W-1:0] out_latitude_e7, out_longitude_e7;
  logic [SPEED_W-1:0] out_speed_centiknots;

  // stall as seen at the last rising edge decides whether the current byte left
  logic in_stall_q = 1'b0;
  logic in_taken;
  assign in_taken = in_valid && !in_stall;

  nmea_rmc_position_parser_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_fix_valid(out_fix_valid), .out_rmc_seen(out_rmc_seen),
    .out_latitude_e7(out_latitude_e7), .out_longitude_e7(out_longitude_e7),
    .out_speed_centiknots(out_speed_centiknots),
    .out_line_overflow(out_line_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // line model state
  // ---------------------------------------------------------------
  int unsigned ln_len, ln_fld, ln_fcnt, ln_fdig;
  logic [15:0] ln_recent;
  bit ln_rmc, ln_active, ln_numdone, ln_point;
  int unsigned lat_w, lat_f, lon_w, lon_f, spd_w, spd_f;
  bit lat_s, lon_wst;

  byte unsigned    pending_bytes[$];   // bytes waiting for the driver
  line_result_t    expected_lines[$];  // results still owed by the block
  int unsigned     mismatch_cnt = 0;
  int unsigned     lines_checked = 0;
  int unsigned     fixes_seen = 0;
  int unsigned     bytes_sent = 0;
  bit              sender_hold = 1'b0;  // pause feeding bytes
  bit              quiet_mode = 1'b0;   // stretch with no idling
  bit              recv_hold_req = 1'b0;
  bit              stim_done = 1'b0;
  int unsigned     idle_cycles = 0;

  function automatic longint unsigned pow10_u(int unsigned n);
    longint unsigned p = 1;
    for (int i = 0; i < n; i++) p *= 10;
    return p;
  endfunction

  task automatic clear_line_model();
    ln_len = 0; ln_recent = 0; ln_rmc = 0; ln_fld = 0; ln_fcnt = 0;
    ln_active = 0; ln_numdone = 0; ln_point = 0; ln_fdig = 0;
    lat_w = 0; lat_f = 0; lat_s = 0; lon_w = 0; lon_f = 0; lon_wst = 0;
    spd_w = 0; spd_f = 0;
  endtask

  // ddmm.mmmmm to signed 1e-7 degree
  function automatic logic signed [COORD_W-1:0] degrees_e7(int unsigned whole,
      int unsigned frac, bit neg);
    longint unsigned scale, mins, mag;
    scale = pow10_u(FRAC_N);
    mins  = longint'(whole % 100) * scale + frac;
    mag   = longint'(whole / 100) * 10000000 + (mins * 10000000) / (60 * scale);
    return neg ? -$signed(mag[COORD_W-1:0]) : $signed(mag[COORD_W-1:0]);
  endfunction

  // one character into a number field: digits and the first point add to it, anything else ends it
  task automatic number_char(byte unsigned c, ref int unsigned whole,
      ref int unsigned frac, input int unsigned flen);
    int unsigned w;
    if (ln_numdone) return;
    if (c >= "0" && c <= "9") begin
      if (!ln_point) begin
        w = whole * 10 + (c - "0");
        whole = (w > WHOLE_MAX) ? WHOLE_MAX : w;
      end else if (ln_fdig < flen) begin
        frac += (c - "0") * pow10_u(flen - 1 - ln_fdig);
        ln_fdig++;
      end
    end else if (c == CH_DOT && !ln_point) begin
      ln_point = 1;
    end else begin
      ln_numdone = 1;
    end
  endtask

  // advance the line model by one accepted byte
  task automatic predict_byte(byte unsigned c);
    line_result_t r;
    bit first;
    if (c == CH_LF || ln_len >= LINE_MAX) begin
      r.rmc = ln_rmc;
      r.ovf = (c != CH_LF);
      r.lat = 0; r.lon = 0; r.spd = 0;
      if (ln_rmc && ln_active) begin
        r.lat = degrees_e7(lat_w, lat_f, lat_s);
        r.lon = degrees_e7(lon_w, lon_f, lon_wst);
        r.spd = SPEED_W'(spd_w * 100 + spd_f);
      end
      r.fix = ln_rmc && ln_active && r.lat != 0 && r.lon != 0;
      expected_lines.push_back(r);
      clear_line_model();
      return;
    end
    ln_len++;
    if (ln_rmc) begin
      if (c == CH_COMMA) begin
        if (ln_fld < FLD_MAX) ln_fld++;
        ln_fcnt = 0; ln_numdone = 0; ln_point = 0; ln_fdig = 0;
      end else begin
        first = (ln_fcnt == 0);
        case (ln_fld)
          FLD_STATUS: if (first && c == CH_A) ln_active = 1;
          FLD_LAT:    number_char(c, lat_w, lat_f, FRAC_N);
          FLD_NS:     if (first && c == CH_S) lat_s = 1;
          FLD_LON:    number_char(c, lon_w, lon_f, FRAC_N);
          FLD_EW:     if (first && c == CH_W) lon_wst = 1;
          FLD_SPEED:  number_char(c, spd_w, spd_f, 2);
          default: ;
        endcase
        if (ln_fcnt < 127) ln_fcnt++;
      end
    end else if (ln_recent == {CH_R, CH_M} && c == CH_C) begin
      ln_rmc = 1; ln_fld = 0; ln_fcnt = 0;
    end
    ln_recent = {ln_recent[7:0], c};
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_cnt++;
    $display("mismatch line %0d %s: got %0d want %0d", lines_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  function automatic string rand_digits(int unsigned n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // random number field; sometimes malformed
  function automatic string rand_number();
    string s;
    case ($urandom_range(0, 9))
      0: s = "";
      1: s = {rand_digits($urandom_range(1, 8)), "-", rand_digits(2)};
      2: s = {rand_digits(3), ".", rand_digits(2), ".", rand_digits(2)};
      default: s = {rand_digits($urandom_range(1, 6)), ".",
                    rand_digits($urandom_range(0, 8))};
    endcase
    return s;
  endfunction

  // a short, mostly well-formed rmc sentence with random content
  task automatic push_rmc_sentence();
    string s, st, ns, ew;
    st = ($urandom_range(0, 4) != 0) ? "A" : (($urandom_range(0, 1)) ? "V" : "");
    ns = ($urandom_range(0, 5) == 0) ? "" : (($urandom_range(0, 1)) ? "S" : "N");
    ew = ($urandom_range(0, 5) == 0) ? "x" : (($urandom_range(0, 1)) ? "W" : "E");
    if ($urandom_range(0, 1)) s = "$GPRMC,0,";
    else s = "$GNRMC,0,";
    s = {s, st, ",", rand_number(), ",", ns, ",", rand_number(), ",", ew, ",",
         rand_number()};
    if ($urandom_range(0, 6) == 0) s = s.substr(0, $urandom_range(4, s.len() - 1));
    push_text(s);
    pending_bytes.push_back(CH_LF);
  endtask

  // random bytes, all 8 bits exercised
  task automatic push_noise_line();
    int unsigned n = $urandom_range(0, 30);
    for (int i = 0; i < n; i++) pending_bytes.push_back(byte'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) pending_bytes.push_back(CH_LF);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // driver: changes inputs at the falling edge
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_q) begin
        if (!sender_hold && pending_bytes.size() != 0 &&
            (quiet_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // receiver stall, with a long hold when asked
  // ---------------------------------------------------------------
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (recv_hold_req && hold_left == 0) begin
      hold_left = STALL_HOLD;
      recv_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------
  // monitor: samples at the rising edge
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    line_result_t e;
    in_stall_q <= in_stall;
    if (rst_n) begin
      if (in_taken) begin
        predict_byte(in_rx_byte);
        bytes_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          e = expected_lines.pop_front();
          if (out_fix_valid !== e.fix) report_mismatch("fix_valid", out_fix_valid, e.fix);
          if (out_rmc_seen !== e.rmc) report_mismatch("rmc_seen", out_rmc_seen, e.rmc);
          if (out_latitude_e7 !== e.lat)
            report_mismatch("latitude_e7", out_latitude_e7, e.lat);
          if (out_longitude_e7 !== e.lon)
            report_mismatch("longitude_e7", out_longitude_e7, e.lon);
          if (out_speed_centiknots !== e.spd)
            report_mismatch("speed_centiknots", out_speed_centiknots, e.spd);
          if (out_line_overflow !== e.ovf)
            report_mismatch("line_overflow", out_line_overflow, e.ovf);
          if (e.fix) fixes_seen++;
        end
        lines_checked++;
      end
      // watchdog over cycles with no transaction at all
      if (in_taken || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------
  initial begin
    clear_line_model();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: typical fix, south/west, inactive status, missing hemispheres
    push_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4\n");
    push_text("$GPRMC,0,A,9959.99999,S,99999.99999,W,99999.99,0\n");
    push_text("$GPRMC,0,V,4807.038,N,01131.000,E,1.5\n");
    push_text("$GPRMC,0,,1,N,1,E\n");
    push_text("$GPRMC,0\n");
    push_text("xxRMC,0,A,1234.5678912,,00012.3,,0.129\n");   // extra fraction digits dropped
    push_text("RMC,0,A,9999999.1,Q,12.3.4,W,-5\n");          // saturation, second point, sign
    push_text("RMCRMC,0,A,1,N,1,E,1\n");                     // second match ignored
    push_text("$GPRMC,0,A,0000.00000,N,0000.00000,E,0\n");    // zero coordinates, no fix
    push_text("$GPRMC,0,A,");                                 // nul byte at the start of a number field
    pending_bytes.push_back(8'h00);
    push_text("12,N,1 2,E,3\n");
    push_text("\n");
    wait_drained();

    // long receiver hold while line ends keep coming, so the queue fills
    recv_hold_req = 1'b1;
    for (int i = 0; i < 16; i++) pending_bytes.push_back(CH_LF);
    wait_drained();

    // sender pause with a line half sent, until every result has come back
    push_rmc_sentence();
    push_rmc_sentence();
    while (pending_bytes.size() > 3) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_lines.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
    push_noise_line();
    pending_bytes.push_back(CH_LF);   // close any open noise line
    wait_drained();

    // stretch without idling: overflow, then newline on a full line
    quiet_mode = 1'b1;
    for (int i = 0; i < 128; i++) pending_bytes.push_back(byte'("x"));
    for (int i = 0; i < 127; i++) pending_bytes.push_back(byte'("y"));
    pending_bytes.push_back(CH_LF);
    pending_bytes.push_back(8'hFF); pending_bytes.push_back(8'h00);
    pending_bytes.push_back(CH_LF);
    wait_drained();
    quiet_mode = 1'b0;
    repeat (30) @(posedge clk);

    $display("parsed %0d bytes into %0d line results, %0d with a fix",
             bytes_sent, lines_checked, fixes_seen);
    if (mismatch_cnt == 0 && expected_lines.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- nmea_rmc_position_parser_top.f -----
src/nrp_pkg.sv
src/nrp_front.sv
src/nrp_queue.sv
src/nrp_coord.sv
src/nrp_back.sv
src/nmea_rmc_position_parser_top.sv
src/nrp_checker.sv
test/nmea_rmc_position_parser_top_tb.sv
